@@ rtl/gfbi_pkg.sv @@
// Shared constants, types and saturation helper for the bilinear interpolation unit.
package gfbi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int V_W          = 32;
  localparam int DEC_PROD_W   = SAMPLE_BITS + V_W;
  localparam int WIDE_W       = DEC_PROD_W + 1;
  localparam int TERM_W       = V_W + 3;
  localparam int TERM_PROD_W  = TERM_W + FRAC_BITS + 1;
  localparam int ACC_W        = V_W + 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MISSING_CODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = CFG_IDX_W'(2);

  localparam logic signed [TERM_PROD_W-1:0] TERM_HALF =
    TERM_PROD_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [V_W-1:0] val;
    logic                  sat;
  } clip_t;

  typedef struct packed {
    logic signed [V_W-1:0] val;
    logic                  sat;
    logic                  miss;
  } dec_t;

  function automatic clip_t clip32(input logic signed [WIDE_W-1:0] x);
    clip_t c;
    if (&x[WIDE_W-1:V_W-1] || ~|x[WIDE_W-1:V_W-1]) begin
      c.val = x[V_W-1:0];
      c.sat = 1'b0;
    end else if (x[WIDE_W-1]) begin
      c.val = {1'b1, {(V_W-1){1'b0}}};
      c.sat = 1'b1;
    end else begin
      c.val = {1'b0, {(V_W-1){1'b1}}};
      c.sat = 1'b1;
    end
    return c;
  endfunction

endpackage

@@ rtl/gfbi_decode_lane.sv @@
// Corner decode lane: missing test, offset + sample * scale, clip to 32 bits.
module gfbi_decode_lane
  import gfbi_pkg::*;
(
  input  logic                          clk,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] missing_code,
  input  logic signed [V_W-1:0]         scale,
  input  logic signed [V_W-1:0]         offset,
  output dec_t                          result
);

  logic signed [DEC_PROD_W-1:0] prod;
  logic                         miss;
  logic signed [WIDE_W-1:0]     sum;
  clip_t                        clipped;

  always_ff @(posedge clk) begin
    prod <= DEC_PROD_W'(sample) * DEC_PROD_W'(scale);
    miss <= (sample == missing_code);
  end

  always_comb begin
    sum     = WIDE_W'(prod) + WIDE_W'(offset);
    clipped = clip32(sum);
  end

  always_ff @(posedge clk) begin
    result.val  <= clipped.val;
    result.sat  <= clipped.sat;
    result.miss <= miss;
  end

endmodule

@@ rtl/gfbi_term_lane.sv @@
// Rounded fractional term: floor((x * t + half) / 2^FRAC_BITS), one register stage.
module gfbi_term_lane
  import gfbi_pkg::*;
(
  input  logic                     clk,
  input  logic signed [TERM_W-1:0] x,
  input  logic [FRAC_BITS-1:0]     t,
  output logic signed [TERM_W-1:0] r
);

  logic signed [TERM_PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= TERM_PROD_W'(x) * TERM_PROD_W'($signed({1'b0, t})) + TERM_HALF;
  end

  assign r = TERM_W'(prod >>> FRAC_BITS);

endmodule

@@ rtl/gridded_field_bilinear_interp_unit.sv @@
// Top level: bilinear interpolation of four grid corners with missing-sample handling.
//
// Usage:
//   Input channel: present corner_a..corner_d, frac_i, frac_j with start high; a
//   transaction is taken at every rising edge where start is high and busy is low.
//   busy stays low, so a new query may be issued every cycle.
//   Output channel: done pulses for one cycle with value, valid_res and saturated.
//   Results come back in issue order; done is registered together with value,
//   valid_res and saturated, behind the decode, term and blend pipeline registers.
//   Throughput is one query per cycle: four decode lanes run side by side, then
//   two term lanes in parallel and a third term lane for the row blend, all
//   fully pipelined with no feedback.
//   Configuration: cfg_we with cfg_index/cfg_data writes missing_code (0), scale (1)
//   or offset (2) at the clock edge; other indexes are ignored. Write only while
//   no query is in flight.
//   Reset (rst, synchronous) restores missing_code -32768, scale 1.0, offset 0 and
//   drops every query in flight. The receiver cannot stall: each result is
//   presented for exactly one cycle.
module gridded_field_bilinear_interp_unit
  import gfbi_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          corner_a,
  input  logic signed [15:0]          corner_b,
  input  logic signed [15:0]          corner_c,
  input  logic signed [15:0]          corner_d,
  input  logic [15:0]                 frac_i,
  input  logic [15:0]                 frac_j,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [V_W-1:0]              cfg_data,
  output logic                        done,
  output logic signed [V_W-1:0]       value,
  output logic                        valid_res,
  output logic                        saturated
);

  localparam logic [3:0] MISS_NONE = 4'b0000;
  localparam logic [3:0] MISS_A    = 4'b0001;
  localparam logic [3:0] MISS_B    = 4'b0010;
  localparam logic [3:0] MISS_C    = 4'b0100;
  localparam logic [3:0] MISS_D    = 4'b1000;

  logic signed [SAMPLE_BITS-1:0] missing_code;
  logic signed [V_W-1:0]         scale;
  logic signed [V_W-1:0]         offset;

  logic accept;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [SAMPLE_BITS-1:0] samp [4];
  dec_t                          dec  [4];

  logic [FRAC_BITS-1:0] ti_1, tj_1, ti_2, tj_2;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_code <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      scale        <= V_W'(65536);
      offset       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MISSING_CODE: missing_code <= cfg_data[SAMPLE_BITS-1:0];
        REG_SCALE:        scale        <= cfg_data;
        REG_OFFSET:       offset       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      done <= v6;
    end
  end

  // decode lanes
  assign samp[0] = corner_a[SAMPLE_BITS-1:0];
  assign samp[1] = corner_b[SAMPLE_BITS-1:0];
  assign samp[2] = corner_c[SAMPLE_BITS-1:0];
  assign samp[3] = corner_d[SAMPLE_BITS-1:0];

  for (genvar k = 0; k < 4; k++) begin : g_dec
    gfbi_decode_lane u_dec (
      .clk          (clk),
      .sample       (samp[k]),
      .missing_code (missing_code),
      .scale        (scale),
      .offset       (offset),
      .result       (dec[k])
    );
  end

  always_ff @(posedge clk) begin
    ti_1 <= frac_i[FRAC_BITS-1:0];
    tj_1 <= frac_j[FRAC_BITS-1:0];
    ti_2 <= ti_1;
    tj_2 <= tj_1;
  end

  // operand select
  logic [3:0]               miss_vec;
  logic signed [TERM_W-1:0] ea, eb, ec, ed;
  logic signed [TERM_W-1:0] x0_c, x1_c;
  logic signed [ACC_W-1:0]  base_c;
  logic [FRAC_BITS-1:0]     t1_c;
  logic                     ok_c, sat_c;

  always_comb begin
    miss_vec = {dec[3].miss, dec[2].miss, dec[1].miss, dec[0].miss};
    ea = TERM_W'(dec[0].val);
    eb = TERM_W'(dec[1].val);
    ec = TERM_W'(dec[2].val);
    ed = TERM_W'(dec[3].val);
    ok_c  = ($countones(miss_vec) < 2);
    sat_c = (dec[0].sat && !dec[0].miss) || (dec[1].sat && !dec[1].miss) ||
            (dec[2].sat && !dec[2].miss) || (dec[3].sat && !dec[3].miss);
    base_c = ACC_W'(ea);
    x0_c   = ec - ea;
    x1_c   = ed - eb;
    t1_c   = tj_2;
    case (miss_vec)
      MISS_NONE: begin
        t1_c = ti_2;
      end
      MISS_A: begin
        base_c = ACC_W'(eb) + ACC_W'(ec) - ACC_W'(ed);
        x0_c   = ed - eb;
        x1_c   = ed - ec;
      end
      MISS_B: begin
        x1_c = ed - ec;
      end
      MISS_C: begin
        x0_c = ed - eb;
        x1_c = eb - ea;
      end
      MISS_D: begin
        x1_c = eb - ea;
      end
      default: ;
    endcase
  end

  logic signed [TERM_W-1:0] x0_3, x1_3;
  logic [FRAC_BITS-1:0]     ti_3, t1_3, tj_3;
  logic signed [ACC_W-1:0]  base_3;
  logic signed [V_W-1:0]    a_3, b_3;
  logic                     nomiss_3, ok_3, sat_3;

  always_ff @(posedge clk) begin
    x0_3     <= x0_c;
    x1_3     <= x1_c;
    ti_3     <= ti_2;
    t1_3     <= t1_c;
    tj_3     <= tj_2;
    base_3   <= base_c;
    a_3      <= dec[0].val;
    b_3      <= dec[1].val;
    nomiss_3 <= (miss_vec == MISS_NONE);
    ok_3     <= ok_c;
    sat_3    <= sat_c;
  end

  // first pair of terms
  logic signed [TERM_W-1:0] r0, r1;

  gfbi_term_lane u_term0 (
    .clk (clk),
    .x   (x0_3),
    .t   (ti_3),
    .r   (r0)
  );

  gfbi_term_lane u_term1 (
    .clk (clk),
    .x   (x1_3),
    .t   (t1_3),
    .r   (r1)
  );

  logic [FRAC_BITS-1:0]    tj_4;
  logic signed [ACC_W-1:0] base_4;
  logic signed [V_W-1:0]   a_4, b_4;
  logic                    nomiss_4, ok_4, sat_4;

  always_ff @(posedge clk) begin
    tj_4     <= tj_3;
    base_4   <= base_3;
    a_4      <= a_3;
    b_4      <= b_3;
    nomiss_4 <= nomiss_3;
    ok_4     <= ok_3;
    sat_4    <= sat_3;
  end

  // row values and plane sum
  logic signed [ACC_W-1:0] top_c, bot_c;

  always_comb begin
    top_c = ACC_W'(a_4) + ACC_W'(r0);
    bot_c = ACC_W'(b_4) + ACC_W'(r1);
  end

  logic signed [ACC_W-1:0]  top_5, sum_5;
  logic signed [TERM_W-1:0] diff_5;
  logic [FRAC_BITS-1:0]     tj_5;
  logic                     nomiss_5, ok_5, sat_5;

  always_ff @(posedge clk) begin
    top_5    <= top_c;
    diff_5   <= TERM_W'(bot_c - top_c);
    sum_5    <= base_4 + ACC_W'(r0) + ACC_W'(r1);
    tj_5     <= tj_4;
    nomiss_5 <= nomiss_4;
    ok_5     <= ok_4;
    sat_5    <= sat_4;
  end

  // column blend
  logic signed [TERM_W-1:0] r2;

  gfbi_term_lane u_term2 (
    .clk (clk),
    .x   (diff_5),
    .t   (tj_5),
    .r   (r2)
  );

  logic signed [ACC_W-1:0] top_6, sum_6;
  logic                    nomiss_6, ok_6, sat_6;

  always_ff @(posedge clk) begin
    top_6    <= top_5;
    sum_6    <= sum_5;
    nomiss_6 <= nomiss_5;
    ok_6     <= ok_5;
    sat_6    <= sat_5;
  end

  logic signed [ACC_W-1:0] res_c;
  clip_t                   fin_c;

  always_comb begin
    res_c = nomiss_6 ? (top_6 + ACC_W'(r2)) : sum_6;
    fin_c = clip32(WIDE_W'(res_c));
  end

  always_ff @(posedge clk) begin
    if (ok_6) begin
      value     <= fin_c.val;
      valid_res <= 1'b1;
      saturated <= fin_c.sat || sat_6;
    end else begin
      value     <= '0;
      valid_res <= 1'b0;
      saturated <= 1'b0;
    end
  end

endmodule
